### sv/tcgr_pkg.sv
// Shared types and constants of the text console glyph renderer.
package tcgr_pkg;

    localparam int GLYPH_BYTES = 16;
    localparam int GLYPH_WIDTH = 8;
    localparam int LINE_HEIGHT = 16;
    localparam int FONT_DEPTH  = 4096;
    localparam int FONT_AW     = $clog2(FONT_DEPTH);
    localparam int ROW_W       = $clog2(GLYPH_BYTES);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int POS_W       = 13;
    localparam int CFG_AW      = 4;

    localparam logic [1:0] REQ_PUT    = 2'd0;
    localparam logic [1:0] REQ_FONT   = 2'd1;
    localparam logic [1:0] REQ_CURSOR = 2'd2;

    localparam logic [7:0] CODE_TAB     = 8'd9;
    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] CODE_RETURN  = 8'd13;
    localparam logic [7:0] CODE_SPACE   = 8'd32;

    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [11:0] WIDTH_RESET  = 12'd640;
    localparam logic [11:0] HEIGHT_RESET = 12'd480;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  char_code;
        logic [31:0] pen_color;
        logic [11:0] font_addr;
        logic [7:0]  font_byte;
        logic [11:0] new_cursor_x;
        logic [11:0] new_cursor_y;
    } t_in_item;

    typedef struct packed {
        logic [12:0] pixel_x;
        logic [12:0] pixel_y;
        logic [7:0]  row_mask;
        logic [31:0] row_color;
        logic        last_row;
    } t_out_item;

    typedef struct packed {
        logic        enable;
        logic [11:0] width;
        logic [11:0] height;
    } t_cfg;

    typedef enum logic {
        Q_DRAW = 1'b0,
        Q_FONT = 1'b1
    } t_q_kind;

    typedef struct packed {
        t_q_kind            kind;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [7:0]         code;
        logic [31:0]        color;
        logic [FONT_AW-1:0] font_addr;
        logic [7:0]         font_byte;
    } t_q_entry;

endpackage

### sv/tcgr_queue.sv
// Short queue of draw and font-write jobs between the front and back parts.
module tcgr_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tcgr_pkg::t_q_entry i_push_entry,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output tcgr_pkg::t_q_entry o_head
);

    tcgr_pkg::t_q_entry                r_slot [tcgr_pkg::QUEUE_DEPTH];
    logic [tcgr_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [tcgr_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [tcgr_pkg::QCNT_W-1:0]       r_count;
    logic [tcgr_pkg::QCNT_W-1:0]       n_count;

    assign o_full  = (r_count == tcgr_pkg::QCNT_W'(tcgr_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_entry;
        end
    end

endmodule

### sv/tcgr_front.sv
// Front part: takes items, keeps the cursor and queues draw and font-write jobs.
module tcgr_front #(
    parameter int TAB_PIXELS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcgr_pkg::t_cfg     i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tcgr_pkg::t_in_item i_in_item,
    input  logic               i_q_full,
    output logic               o_push,
    output tcgr_pkg::t_q_entry o_push_entry
);

    localparam int          PW       = tcgr_pkg::POS_W;
    localparam logic [PW:0] TAB_STEP = (PW+1)'(TAB_PIXELS);
    localparam logic [PW:0] GLY_STEP = (PW+1)'(tcgr_pkg::GLYPH_WIDTH);

    logic [PW-1:0] r_col;
    logic [PW-1:0] r_row;
    logic [PW-1:0] n_col;
    logic [PW-1:0] n_row;

    logic          accept;
    logic          live;
    logic          tab_wrap;
    logic          gly_wrap;
    logic [PW:0]   width_ext;
    logic [PW-1:0] row_down;
    logic [PW-1:0] draw_col;
    logic [PW-1:0] draw_row;

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;

    assign width_ext = (PW+1)'(i_cfg.width);
    assign tab_wrap  = ({1'b0, r_col} + TAB_STEP) >= width_ext;
    assign gly_wrap  = ({1'b0, r_col} + GLY_STEP) >= width_ext;
    assign row_down  = r_row + PW'(tcgr_pkg::LINE_HEIGHT);
    assign live      = i_cfg.enable && (r_row < PW'(i_cfg.height));

    // printable characters wrap before they are drawn
    assign draw_col = gly_wrap ? '0 : r_col;
    assign draw_row = gly_wrap ? row_down : r_row;

    always_comb begin
        o_push_entry.kind      = tcgr_pkg::Q_DRAW;
        o_push_entry.x         = draw_col;
        o_push_entry.y         = draw_row;
        o_push_entry.code      = i_in_item.char_code;
        o_push_entry.color     = i_in_item.pen_color;
        o_push_entry.font_addr = i_in_item.font_addr;
        o_push_entry.font_byte = i_in_item.font_byte;
        o_push = 1'b0;
        n_col  = r_col;
        n_row  = r_row;
        if (accept) begin
            unique case (i_in_item.req_type)
                tcgr_pkg::REQ_PUT: begin
                    if (live) begin
                        priority if (i_in_item.char_code == tcgr_pkg::CODE_NEWLINE) begin
                            n_col = '0;
                            n_row = row_down;
                        end else if (i_in_item.char_code == tcgr_pkg::CODE_RETURN) begin
                            n_col = '0;
                        end else if (i_in_item.char_code == tcgr_pkg::CODE_TAB) begin
                            n_col = tab_wrap ? TAB_STEP[PW-1:0] : r_col + TAB_STEP[PW-1:0];
                            n_row = tab_wrap ? row_down : r_row;
                        end else if (i_in_item.char_code == tcgr_pkg::CODE_SPACE) begin
                            n_col = draw_col + GLY_STEP[PW-1:0];
                            n_row = draw_row;
                        end else begin
                            o_push = 1'b1;
                            n_col  = draw_col + GLY_STEP[PW-1:0];
                            n_row  = draw_row;
                        end
                    end
                end
                tcgr_pkg::REQ_FONT: begin
                    o_push            = 1'b1;
                    o_push_entry.kind = tcgr_pkg::Q_FONT;
                end
                tcgr_pkg::REQ_CURSOR: begin
                    n_col = PW'(i_in_item.new_cursor_x);
                    n_row = PW'(i_in_item.new_cursor_y);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

### sv/tcgr_back.sv
// Back part: font store, glyph row reads and the output register.
module tcgr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  tcgr_pkg::t_q_entry  i_q_head,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tcgr_pkg::t_out_item o_out_item
);

    localparam int PW = tcgr_pkg::POS_W;
    localparam int RW = tcgr_pkg::ROW_W;
    localparam logic [RW-1:0] ROW_LAST = RW'(tcgr_pkg::GLYPH_BYTES - 1);

    logic [7:0] r_font [tcgr_pkg::FONT_DEPTH];

    // job being drawn
    logic          r_busy;
    logic [RW-1:0] r_row;
    logic [7:0]    r_code;
    logic [PW-1:0] r_x;
    logic [PW-1:0] r_y;
    logic [31:0]   r_color;

    // read stage
    logic          r_rd_valid;
    logic [7:0]    r_rd_mask;
    logic [PW-1:0] r_rd_x;
    logic [PW-1:0] r_rd_y;
    logic [31:0]   r_rd_color;
    logic          r_rd_last;

    // output stage
    logic                r_out_valid;
    tcgr_pkg::t_out_item r_out_item;

    logic out_free;
    logic rd_load;
    logic issue;
    logic last_issue;
    logic font_wr;
    logic [tcgr_pkg::FONT_AW-1:0] rd_addr;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign rd_load    = !r_rd_valid || out_free;
    assign issue      = r_busy && rd_load;
    assign last_issue = issue && (r_row == ROW_LAST);
    assign o_pop      = i_q_valid && (!r_busy || last_issue);
    assign font_wr    = o_pop && (i_q_head.kind == tcgr_pkg::Q_FONT);
    assign rd_addr    = tcgr_pkg::FONT_AW'({r_code, r_row});

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= '0;
        end else begin
            if (o_pop && (i_q_head.kind == tcgr_pkg::Q_DRAW)) begin
                r_busy <= 1'b1;
                r_row  <= '0;
            end else if (last_issue) begin
                r_busy <= 1'b0;
            end else if (issue) begin
                r_row <= r_row + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_q_head.kind == tcgr_pkg::Q_DRAW)) begin
            r_code  <= i_q_head.code;
            r_x     <= i_q_head.x;
            r_y     <= i_q_head.y;
            r_color <= i_q_head.color;
        end
    end

    // a write in the cycle of the last row read lands after that read
    always_ff @(posedge i_clk) begin
        if (font_wr) begin
            r_font[i_q_head.font_addr] <= i_q_head.font_byte;
        end
        if (issue) begin
            r_rd_mask <= r_font[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_x     <= r_x;
            r_rd_y     <= r_y + PW'(r_row);
            r_rd_color <= r_color;
            r_rd_last  <= (r_row == ROW_LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rd_load) begin
                r_rd_valid <= issue;
            end
            if (out_free) begin
                r_out_valid <= r_rd_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_rd_valid) begin
            r_out_item.pixel_x   <= r_rd_x;
            r_out_item.pixel_y   <= r_rd_y;
            r_out_item.row_mask  <= r_rd_mask;
            r_out_item.row_color <= r_rd_color;
            r_out_item.last_row  <= r_rd_last;
        end
    end

endmodule

### sv/text_console_glyph_renderer_unit.sv
// Top level of the text console glyph renderer: register port and part wiring.
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+---------------------
//  in       | in        | i_in_valid / o_in_stall | i_in_item  (t_in_item)
//  out      | out       | o_out_valid / i_out_stall | o_out_item (t_out_item)
//  config   | in        | APB psel/penable/pready | pwdata / prdata
//
// A printable character takes one font store read per glyph row in the back
// part; each row passes the read stage, then the output register. Control
// codes, set-cursor and ignored items stay in the front part; a font load is
// written as it leaves the queue. The front runs ahead by up to two jobs.
// Synchronous active-low reset clears cursor, queue and pipeline; the font store
// is not cleared. The input stalls only while the two-entry queue is full.
module text_console_glyph_renderer_unit #(
    parameter int TAB_PIXELS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  tcgr_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output tcgr_pkg::t_out_item           o_out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcgr_pkg::CFG_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    tcgr_pkg::t_cfg     r_cfg;
    logic               cfg_wr;
    logic [1:0]         reg_idx;
    logic               q_full;
    logic               q_valid;
    logic               push;
    logic               pop;
    tcgr_pkg::t_q_entry push_entry;
    tcgr_pkg::t_q_entry q_head;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable <= 1'b0;
            r_cfg.width  <= tcgr_pkg::WIDTH_RESET;
            r_cfg.height <= tcgr_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                tcgr_pkg::REG_ENABLE: r_cfg.enable <= pwdata[0];
                tcgr_pkg::REG_WIDTH:  r_cfg.width  <= pwdata[11:0];
                tcgr_pkg::REG_HEIGHT: r_cfg.height <= pwdata[11:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            tcgr_pkg::REG_ENABLE: prdata = {31'b0, r_cfg.enable};
            tcgr_pkg::REG_WIDTH:  prdata = {20'b0, r_cfg.width};
            tcgr_pkg::REG_HEIGHT: prdata = {20'b0, r_cfg.height};
            default:              prdata = '0;
        endcase
    end

    tcgr_front #(
        .TAB_PIXELS(TAB_PIXELS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_push_entry (push_entry)
    );

    tcgr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_entry (push_entry),
        .o_full       (q_full),
        .i_pop        (pop),
        .o_valid      (q_valid),
        .o_head       (q_head)
    );

    tcgr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
